>>> hdl/isti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isti_pkg
// Shared constants and command/status types of the IMU sample interpolator.
// ----------------------------------------------------------------------------
package isti_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	// Opcode with no meaning: the request is taken and dropped.
	localparam logic [1:0] OP_IGNORE = 2'd3;

	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_ORDER   = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_FIRST   = 3'd4;
	localparam logic [2:0] ST_LAST    = 3'd5;
	localparam logic [2:0] ST_INTERP  = 3'd6;
	localparam logic [2:0] ST_CLEARED = 3'd7;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic             latch_in;   // capture the input request
		logic             write_smp;  // store the captured sample at count
		logic             clr_cnt;
		logic             rd_en;      // read the memories at rd_addr
		logic [IDX_W-1:0] rd_addr;
		logic             cap_lo;     // capture read data as the lower sample
		logic             cap_hi;     // capture read data as the upper sample
		logic             div_start;
		logic             blank;      // load result: blank axes
		logic             sample;     // load result: read sample unchanged
		logic             interp;     // load result: interpolated axes
		logic [2:0]       status;
	} ctl_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [31:0]      rd_time;   // registered read time
		logic [31:0]      in_time;
		logic             div_done;
	} sts_t;

endpackage
`default_nettype wire

>>> hdl/isti_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isti_datapath
// Sample memories, sample count, lower/upper sample registers, a shared
// restoring divider for the six axes, and the result register.
// ----------------------------------------------------------------------------
module isti_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire isti_pkg::ctl_t  ctl,
	input  wire logic [31:0]     item_time,
	input  wire logic [95:0]     in_axes,
	output isti_pkg::sts_t       sts,
	output logic [2:0]           res_status,
	output logic [31:0]          res_time,
	output logic [95:0]          res_axes
);

	logic [31:0] time_mem [isti_pkg::STORE_DEPTH];
	logic [95:0] axes_mem [isti_pkg::STORE_DEPTH];
	logic [31:0] rd_time_q;
	logic [95:0] rd_axes_q;
	logic [31:0] in_time_q;
	logic [95:0] in_axes_q;
	logic [isti_pkg::CNT_W-1:0] count_q;
	logic [31:0] lo_time_q;
	logic [95:0] lo_axes_q;
	logic [95:0] hi_axes_q;

	always_ff @(posedge clk) begin
		if (ctl.write_smp) begin
			time_mem[count_q[isti_pkg::IDX_W-1:0]] <= in_time_q;
			axes_mem[count_q[isti_pkg::IDX_W-1:0]] <= in_axes_q;
		end
		if (ctl.rd_en) begin
			rd_time_q <= time_mem[ctl.rd_addr];
			rd_axes_q <= axes_mem[ctl.rd_addr];
		end
		if (ctl.latch_in) begin
			in_time_q <= item_time;
			in_axes_q <= in_axes;
		end
		if (ctl.cap_lo) begin
			lo_time_q <= rd_time_q;
			lo_axes_q <= rd_axes_q;
		end
		if (ctl.cap_hi) hi_axes_q <= rd_axes_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clr_cnt) begin
			count_q <= '0;
		end else if (ctl.write_smp) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Divider: for each axis, q = (2*num*|d| + dt) / (2*dt), one quotient bit
	// a cycle. num*|d| < 2^49, so the dividend fits in 50 bits.
	logic [2:0]  axis_q;
	logic [5:0]  bit_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] den_q;            // 2*dt
	logic [49:0] dvd_q;
	logic [33:0] rem_q;
	logic [49:0] quo_q;
	logic [15:0] a0_q;
	logic        neg_q;
	logic [95:0] acc_q;
	logic [31:0] hi_time_q;

	logic [15:0] a0_sel, a1_sel;
	logic [16:0] diff;
	logic [16:0] mag;
	logic [48:0] prod;
	logic [33:0] rem_sh;
	logic [15:0] axis_res;
	logic [31:0] num;

	always_comb begin
		a0_sel = lo_axes_q[16*axis_q +: 16];
		a1_sel = hi_axes_q[16*axis_q +: 16];
		diff = {a1_sel[15], a1_sel} - {a0_sel[15], a0_sel};
		mag = diff[16] ? (~diff + 17'd1) : diff;
		num = in_time_q - lo_time_q;
		prod = {17'd0, num} * {32'd0, mag};
		rem_sh = {rem_q[32:0], dvd_q[49]};
		axis_res = neg_q ? (a0_q - quo_q[15:0]) : (a0_q + quo_q[15:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_hi) hi_time_q <= rd_time_q;
		if (ctl.div_start || (done_q && busy_q)) begin
			den_q <= {hi_time_q, 1'b0} - {lo_time_q, 1'b0};
		end
		if (ctl.div_start) begin
			axis_q <= 3'd0;
			done_q <= 1'b0;
			bit_q <= 6'd0;
			busy_q <= 1'b0;
		end else if (!done_q) begin
			if (!busy_q) begin
				// Set up one axis.
				dvd_q <= {prod, 1'b0} + {18'd0, hi_time_q - lo_time_q};
				rem_q <= '0;
				quo_q <= '0;
				a0_q <= a0_sel;
				neg_q <= diff[16];
				bit_q <= 6'd0;
				busy_q <= 1'b1;
				den_q <= {hi_time_q - lo_time_q, 1'b0};
			end else if (bit_q != 6'd50) begin
				dvd_q <= {dvd_q[48:0], 1'b0};
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo_q <= {quo_q[48:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[48:0], 1'b0};
				end
				bit_q <= bit_q + 6'd1;
			end else begin
				acc_q[16*axis_q +: 16] <= axis_res;
				busy_q <= 1'b0;
				if (axis_q == 3'd5) done_q <= 1'b1;
				else axis_q <= axis_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.blank) begin
			res_status <= ctl.status;
			res_time <= in_time_q;
			res_axes <= '0;
		end else if (ctl.sample) begin
			res_status <= ctl.status;
			res_time <= rd_time_q;
			res_axes <= rd_axes_q;
		end else if (ctl.interp) begin
			res_status <= isti_pkg::ST_INTERP;
			res_time <= in_time_q;
			res_axes <= acc_q;
		end
	end

	assign sts.count = count_q;
	assign sts.rd_time = rd_time_q;
	assign sts.in_time = in_time_q;
	assign sts.div_done = done_q;

endmodule
`default_nettype wire

>>> hdl/isti_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isti_ctrl
// Controller: decodes a request, runs the binary search over the stored
// times and sequences the divider and the result handshake.
// ----------------------------------------------------------------------------
module isti_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      opcode,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire isti_pkg::sts_t  sts,
	output isti_pkg::ctl_t       ctl
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_RDLAST = 4'd2;
	localparam logic [3:0] S_APCHK  = 4'd3;
	localparam logic [3:0] S_RDFST  = 4'd4;
	localparam logic [3:0] S_FSTCHK = 4'd5;
	localparam logic [3:0] S_LSTCHK = 4'd6;
	localparam logic [3:0] S_SRCH   = 4'd7;
	localparam logic [3:0] S_SCHK   = 4'd8;
	localparam logic [3:0] S_RDHI   = 4'd9;
	localparam logic [3:0] S_RDLO   = 4'd10;
	localparam logic [3:0] S_CAPLO  = 4'd11;
	localparam logic [3:0] S_DIV    = 4'd12;
	localparam logic [3:0] S_DIVW   = 4'd13;
	localparam logic [3:0] S_OUT    = 4'd14;

	localparam int CW = isti_pkg::CNT_W;

	logic [3:0]    state_q;
	logic [1:0]    op_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [CW-1:0] mid;
	logic [CW-1:0] last;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign last = sts.count - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= isti_pkg::OP_APPEND;
			lo_q <= '0;
			hi_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid && opcode != isti_pkg::OP_IGNORE) begin
					op_q <= opcode;
					state_q <= S_DEC;
				end
				S_DEC: begin
					case (op_q)
						isti_pkg::OP_APPEND:
							if (sts.count >= CW'(isti_pkg::STORE_DEPTH)) state_q <= S_OUT;
							else if (sts.count == '0) state_q <= S_OUT;
							else state_q <= S_RDLAST;
						isti_pkg::OP_QUERY:
							if (sts.count == '0) state_q <= S_OUT;
							else state_q <= S_RDFST;
						default: state_q <= S_OUT;
					endcase
				end
				S_RDLAST: state_q <= S_APCHK;
				S_APCHK: state_q <= S_OUT;
				S_RDFST: state_q <= S_FSTCHK;
				S_FSTCHK: if (sts.in_time <= sts.rd_time) state_q <= S_OUT;
					else state_q <= S_RDLAST;
				S_LSTCHK: state_q <= S_OUT;
				S_SRCH: state_q <= S_SCHK;
				S_SCHK: begin
					if (sts.rd_time < sts.in_time) lo_q <= mid + 1'b1;
					else hi_q <= mid;
					state_q <= S_SRCH;
					if ((sts.rd_time < sts.in_time) ? (mid + 1'b1 == hi_q) : (lo_q == mid))
						state_q <= S_RDHI;
				end
				S_RDHI: state_q <= S_RDLO;
				S_RDLO: state_q <= S_CAPLO;
				S_CAPLO: state_q <= S_DIV;
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (sts.div_done) state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			// Query reaching the last-sample check: last read came from RDLAST.
			if (state_q == S_APCHK && op_q == isti_pkg::OP_QUERY) begin
				if (sts.in_time >= sts.rd_time) state_q <= S_OUT;
				else begin
					lo_q <= '0;
					hi_q <= sts.count;
					state_q <= S_SRCH;
				end
			end
		end
	end

	always_comb begin
		ctl = '0;
		ctl.latch_in = (state_q == S_IDLE) && in_valid;
		ctl.rd_addr = '0;
		case (state_q)
			S_DEC: begin
				if (op_q == isti_pkg::OP_APPEND) begin
					if (sts.count >= CW'(isti_pkg::STORE_DEPTH)) begin
						ctl.blank = 1'b1;
						ctl.status = isti_pkg::ST_FULL;
					end else if (sts.count == '0) begin
						ctl.blank = 1'b1;
						ctl.status = isti_pkg::ST_STORED;
						ctl.write_smp = 1'b1;
					end
				end else if (op_q == isti_pkg::OP_QUERY) begin
					if (sts.count == '0) begin
						ctl.blank = 1'b1;
						ctl.status = isti_pkg::ST_EMPTY;
					end
				end else begin
					ctl.blank = 1'b1;
					ctl.status = isti_pkg::ST_CLEARED;
					ctl.clr_cnt = 1'b1;
				end
			end
			S_RDLAST: begin
				ctl.rd_en = 1'b1;
				ctl.rd_addr = last[isti_pkg::IDX_W-1:0];
			end
			S_APCHK: begin
				if (op_q == isti_pkg::OP_APPEND) begin
					ctl.blank = 1'b1;
					if (sts.in_time <= sts.rd_time) ctl.status = isti_pkg::ST_ORDER;
					else begin
						ctl.status = isti_pkg::ST_STORED;
						ctl.write_smp = 1'b1;
					end
				end else if (sts.in_time >= sts.rd_time) begin
					ctl.sample = 1'b1;
					ctl.status = isti_pkg::ST_LAST;
				end
			end
			S_RDFST: ctl.rd_en = 1'b1;
			S_FSTCHK: if (sts.in_time <= sts.rd_time) begin
				ctl.sample = 1'b1;
				ctl.status = isti_pkg::ST_FIRST;
			end
			S_SRCH: begin
				ctl.rd_en = 1'b1;
				ctl.rd_addr = mid[isti_pkg::IDX_W-1:0];
			end
			S_RDHI: begin
				ctl.rd_en = 1'b1;
				ctl.rd_addr = lo_q[isti_pkg::IDX_W-1:0];
			end
			S_RDLO: begin
				ctl.rd_en = 1'b1;
				ctl.rd_addr = lo_q[isti_pkg::IDX_W-1:0] - 1'b1;
				ctl.cap_hi = 1'b1;
			end
			S_CAPLO: ctl.cap_lo = 1'b1;
			S_DIV: ctl.div_start = 1'b1;
			S_DIVW: if (sts.div_done) ctl.interp = 1'b1;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/imu_sample_time_interpolator.sv
`default_nettype none
// Queries run the binary search and then the shared serial divider, which
// works through the six axes one after another. One request is in flight
// at a time.
// Reset empties the store at once: the sample count clears and the memories
// keep no reset value.
// ----------------------------------------------------------------------------
// imu_sample_time_interpolator
// Time-ordered IMU sample store with linear interpolation at a query time.
// ----------------------------------------------------------------------------
module imu_sample_time_interpolator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic [31:0]        item_time,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [31:0]             result_time,
	output logic signed [15:0]      out_accel_x,
	output logic signed [15:0]      out_accel_y,
	output logic signed [15:0]      out_accel_z,
	output logic signed [15:0]      out_gyro_x,
	output logic signed [15:0]      out_gyro_y,
	output logic signed [15:0]      out_gyro_z
);

	isti_pkg::ctl_t ctl;
	isti_pkg::sts_t sts;
	logic [95:0] res_axes;

	isti_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .ctl(ctl)
	);

	isti_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .item_time(item_time),
		.in_axes({gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x}),
		.sts(sts), .res_status(status), .res_time(result_time),
		.res_axes(res_axes)
	);

	assign out_accel_x = res_axes[15:0];
	assign out_accel_y = res_axes[31:16];
	assign out_accel_z = res_axes[47:32];
	assign out_gyro_x  = res_axes[63:48];
	assign out_gyro_y  = res_axes[79:64];
	assign out_gyro_z  = res_axes[95:80];

endmodule
`default_nettype wire

>>> hdl/isti_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isti_checker
// Port-level checks of the interpolator.
// ----------------------------------------------------------------------------
module isti_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  opcode,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [31:0] result_time
);

	// One request at a time: a result never coexists with a new acceptance.
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request accepted while result pending");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_time))
		else $error("stalled result changed");

	// A request with a meaningful opcode keeps the block busy afterwards.
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode != isti_pkg::OP_IGNORE |=> in_stall)
		else $error("accept did not start work");

endmodule

bind imu_sample_time_interpolator isti_checker u_isti_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.opcode(opcode), .out_valid(out_valid), .out_stall(out_stall), .status(status),
	.result_time(result_time)
);
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives appends, queries, clears and ignored opcodes into the IMU sample
// interpolator, predicts every result from a local copy of the store and
// checks each result field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [2:0]         st;
		logic [31:0]        t;
		logic signed [15:0] ax [6];
	} imu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = isti_pkg::OP_APPEND;
	logic [31:0] item_time = '0;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [31:0] result_time;
	logic signed [15:0] out_accel_x, out_accel_y, out_accel_z;
	logic signed [15:0] out_gyro_x, out_gyro_y, out_gyro_z;

	imu_sample_time_interpolator dut (.*);

	// Local copy of the sample store.
	logic [31:0]        smp_time [isti_pkg::STORE_DEPTH];
	logic signed [15:0] smp_axis [isti_pkg::STORE_DEPTH][6];
	int                 smp_count = 0;

	imu_result_t pending_results [$];
	bit  failed = 1'b0;
	longint cycle_count = 0;

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic signed [15:0] lerp_axis(int a0, int a1, longint num,
			longint den);
		int diff;
		longint mag, q;
		diff = a1 - a0;
		mag = diff < 0 ? -diff : diff;
		q = (2 * num * mag + den) / (2 * den);
		return 16'(diff < 0 ? longint'(a0) - q : longint'(a0) + q);
	endfunction

	// Predicts the result of one request and updates the local store.
	function automatic bit predict_request(logic [1:0] op, logic [31:0] t,
			logic signed [15:0] a [6], output imu_result_t r);
		int lo, hi, mid;
		r.st = isti_pkg::ST_STORED;
		r.t = t;
		for (int k = 0; k < 6; k++) r.ax[k] = '0;
		if (op == isti_pkg::OP_APPEND) begin
			if (smp_count >= isti_pkg::STORE_DEPTH) r.st = isti_pkg::ST_FULL;
			else if (smp_count > 0 && t <= smp_time[smp_count-1]) r.st = isti_pkg::ST_ORDER;
			else begin
				smp_time[smp_count] = t;
				for (int k = 0; k < 6; k++) smp_axis[smp_count][k] = a[k];
				smp_count++;
			end
			return 1'b1;
		end
		if (op == isti_pkg::OP_CLEAR) begin
			smp_count = 0;
			r.st = isti_pkg::ST_CLEARED;
			return 1'b1;
		end
		if (op != isti_pkg::OP_QUERY) return 1'b0;
		if (smp_count == 0) begin
			r.st = isti_pkg::ST_EMPTY;
			return 1'b1;
		end
		if (t <= smp_time[0]) begin
			r.st = isti_pkg::ST_FIRST;
			r.t = smp_time[0];
			for (int k = 0; k < 6; k++) r.ax[k] = smp_axis[0][k];
			return 1'b1;
		end
		if (t >= smp_time[smp_count-1]) begin
			r.st = isti_pkg::ST_LAST;
			r.t = smp_time[smp_count-1];
			for (int k = 0; k < 6; k++) r.ax[k] = smp_axis[smp_count-1][k];
			return 1'b1;
		end
		lo = 0;
		hi = smp_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (smp_time[mid] < t) lo = mid + 1;
			else hi = mid;
		end
		r.st = isti_pkg::ST_INTERP;
		for (int k = 0; k < 6; k++)
			r.ax[k] = lerp_axis(smp_axis[lo-1][k], smp_axis[lo][k],
				longint'(t) - longint'(smp_time[lo-1]),
				longint'(smp_time[lo]) - longint'(smp_time[lo-1]));
		return 1'b1;
	endfunction

	// Sends one request after a random gap and records its expected result.
	// Valid stays high into the next request when that one has no gap.
	task automatic send_request(logic [1:0] op, logic [31:0] t,
			logic signed [15:0] a [6]);
		imu_result_t r;
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		item_time <= t;
		accel_x <= a[0]; accel_y <= a[1]; accel_z <= a[2];
		gyro_x <= a[3]; gyro_y <= a[4]; gyro_z <= a[5];
		do @(posedge clk); while (in_stall);
		if (predict_request(op, t, a, r)) pending_results = {pending_results, r};
	endtask

	task automatic send_random_sample(logic [1:0] op, logic [31:0] t);
		logic signed [15:0] a [6];
		for (int k = 0; k < 6; k++) a[k] = 16'($urandom);
		send_request(op, t, a);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Result checker with random receiver stalls.
	initial begin
		int hold;
		imu_result_t e;
		logic signed [15:0] got [6];
		forever begin
			hold = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0) hold = 0;
			out_stall <= hold != 0;
			repeat (hold) @(posedge clk);
			if (hold != 0) out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got = '{out_accel_x, out_accel_y, out_accel_z,
				out_gyro_x, out_gyro_y, out_gyro_z};
			if (pending_results.size() == 0) begin
				$display("%0t: result expected none actual status %0d", $time, status);
				failed = 1'b1;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					failed = 1'b1;
				end
				if (result_time !== e.t) begin
					$display("%0t: result_time expected %0d actual %0d", $time, e.t,
						result_time);
					failed = 1'b1;
				end
				for (int k = 0; k < 6; k++)
					if (got[k] !== e.ax[k]) begin
						$display("%0t: axis %0d expected %0d actual %0d", $time, k,
							e.ax[k], got[k]);
						failed = 1'b1;
					end
			end
		end
	end

	task automatic test_edge_cases();
		logic signed [15:0] a [6];
		send_random_sample(isti_pkg::OP_QUERY, 32'd5);
		a = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001};
		send_request(isti_pkg::OP_APPEND, 32'd0, a);
		send_random_sample(isti_pkg::OP_APPEND, 32'd0);
		a = '{-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh0000};
		send_request(isti_pkg::OP_APPEND, 32'd3, a);
		send_random_sample(isti_pkg::OP_QUERY, 32'd0);
		send_random_sample(isti_pkg::OP_QUERY, 32'd1);
		send_random_sample(isti_pkg::OP_QUERY, 32'd2);
		send_random_sample(isti_pkg::OP_QUERY, 32'd3);
		send_random_sample(isti_pkg::OP_APPEND, 32'hFFFF_FFFF);
		send_random_sample(isti_pkg::OP_QUERY, 32'hFFFF_FFFE);
		send_random_sample(isti_pkg::OP_QUERY, 32'h8000_0000);
		send_random_sample(isti_pkg::OP_QUERY, 32'hFFFF_FFFF);
		send_random_sample(isti_pkg::OP_IGNORE, 32'd7);
		send_random_sample(isti_pkg::OP_APPEND, 32'hFFFF_FFFF);
		send_random_sample(isti_pkg::OP_CLEAR, 32'hFFFF_FFFF);
		send_random_sample(isti_pkg::OP_QUERY, 32'd9);
		wait_drained();
	endtask

	// Fills the store to capacity, overflows it, then queries it and clears it.
	task automatic test_full_store();
		for (int i = 0; i < isti_pkg::STORE_DEPTH; i++)
			send_random_sample(isti_pkg::OP_APPEND, 32'(i * 1000 + $urandom_range(0, 999)));
		send_random_sample(isti_pkg::OP_APPEND, 32'hFFFF_FFF0);
		send_random_sample(isti_pkg::OP_APPEND, 32'd1);
		for (int i = 0; i < 20; i++)
			send_random_sample(isti_pkg::OP_QUERY,
				$urandom_range(0, isti_pkg::STORE_DEPTH * 1000 + 10));
		send_random_sample(isti_pkg::OP_CLEAR, $urandom);
	endtask

	// Runs of appends with random spacing followed by queries, some noise.
	task automatic test_random_sequences();
		logic [31:0] t;
		int n, kind;
		for (int s = 0; s < 30; s++) begin
			n = $urandom_range(1, 12);
			t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
			for (int i = 0; i < n; i++) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) send_random_sample(isti_pkg::OP_APPEND, $urandom);
				else begin
					t = t + (kind < 5 ? $urandom_range(1, 9) : $urandom_range(1, 1 << 20));
					if (kind == 9) t = t + ($urandom & 32'h7FFF_FFFF);
					send_random_sample(isti_pkg::OP_APPEND, t);
				end
			end
			for (int i = 0; i < 25; i++) begin
				kind = $urandom_range(0, 19);
				if (kind == 0) send_random_sample(isti_pkg::OP_IGNORE, $urandom);
				else if (kind == 1) send_random_sample(isti_pkg::OP_QUERY, $urandom);
				else if (smp_count > 0)
					send_random_sample(isti_pkg::OP_QUERY, smp_time[0] + $urandom_range(0,
						smp_time[smp_count-1] - smp_time[0] < 32'h4000_0000 ?
						smp_time[smp_count-1] - smp_time[0] + 1 : 32'h4000_0000));
				else send_random_sample(isti_pkg::OP_QUERY, $urandom);
			end
			send_random_sample(isti_pkg::OP_CLEAR, $urandom);
			if (s == 15) wait_drained();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_full_store();
		test_random_sequences();
		wait_drained();
		if (!failed) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
